>>> hw/rtl/uvtp_pkg.sv
// Package with the shared constants, codes and types of the UUID v4 text parser.
`timescale 1ns / 1ps
`default_nettype none

package uvtp_pkg;

    // Text layout
    localparam int unsigned POS_W         = 6;
    localparam logic [5:0]  POS_MAX       = 6'd63;
    localparam logic [5:0]  POS_LAST      = 6'd35;
    localparam logic [5:0]  POS_HYPHEN_A  = 6'd8;
    localparam logic [5:0]  POS_HYPHEN_B  = 6'd13;
    localparam logic [5:0]  POS_HYPHEN_C  = 6'd18;
    localparam logic [5:0]  POS_HYPHEN_D  = 6'd23;
    localparam logic [5:0]  POS_VERSION   = 6'd14;
    localparam logic [5:0]  POS_VARIANT   = 6'd19;

    // Characters of interest
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_FOUR   = 8'h34;
    localparam logic [7:0] CHAR_EIGHT  = 8'h38;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UC_A   = 8'h41;
    localparam logic [7:0] CHAR_UC_F   = 8'h46;
    localparam logic [7:0] CHAR_LC_A   = 8'h61;
    localparam logic [7:0] CHAR_LC_B   = 8'h62;
    localparam logic [7:0] CHAR_LC_F   = 8'h66;

    // Fault codes, lowest nonzero code has priority
    localparam logic [2:0] FAULT_NONE    = 3'd0;
    localparam logic [2:0] FAULT_LENGTH  = 3'd1;
    localparam logic [2:0] FAULT_HYPHEN  = 3'd2;
    localparam logic [2:0] FAULT_VERSION = 3'd3;
    localparam logic [2:0] FAULT_VARIANT = 3'd4;
    localparam logic [2:0] FAULT_NONHEX  = 3'd5;
    localparam logic [2:0] FAULT_STRAY   = 3'd6;

    // Flag bit positions (code minus one)
    localparam int unsigned FLAG_LENGTH  = 0;
    localparam int unsigned FLAG_HYPHEN  = 1;
    localparam int unsigned FLAG_VERSION = 2;
    localparam int unsigned FLAG_VARIANT = 3;
    localparam int unsigned FLAG_NONHEX  = 4;
    localparam int unsigned FLAG_STRAY   = 5;
    localparam int unsigned FLAG_W       = 6;

    // Per-character classification
    typedef struct packed {
        logic [FLAG_W-1:0] fault_set;
        logic              shift_en;
        logic [3:0]        nibble;
    } uvtp_char_info_t;

    // One result beat
    typedef struct packed {
        logic        parse_ok;
        logic [63:0] value_high;
        logic [63:0] value_low;
        logic [2:0]  fault_code;
    } uvtp_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/uvtp_channels.sv
// Valid/ready channel interfaces for character beats and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface uvtp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_mark;

    modport source (output valid, output char_in, output end_mark, input ready);
    modport sink (input valid, input char_in, input end_mark, output ready);
endinterface

interface uvtp_result_if;
    logic        valid;
    logic        ready;
    logic        parse_ok;
    logic [63:0] value_high;
    logic [63:0] value_low;
    logic [2:0]  fault_code;

    modport source (output valid, output parse_ok, output value_high, output value_low,
                    output fault_code, input ready);
    modport sink (input valid, input parse_ok, input value_high, input value_low,
                  input fault_code, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/uvtp_core_top.sv
// Top level of the UUID v4 text parser: input register, parse state and result register.
// Result beats are registered after the final character passes the input register.
// Throughput: one character beat per cycle, sustained while the result sink keeps up.
// A final character waits in the input register only while the result register is full.
// Reset: asynchronous active-low rst_n clears the position, faults, value and valid bits.
`timescale 1ns / 1ps
`default_nettype none

module uuid_v4_text_parser_core
    import uvtp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    uvtp_char_if.sink     chars,
    uvtp_result_if.source result
);

    logic         step;
    logic [7:0]   char_q;
    logic         last_q;
    logic         res_free;
    uvtp_result_t res_data;

    // Character beats enter a one-deep input register.
    uvtp_input_reg u_input (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_free (res_free),
        .step     (step),
        .char_out (char_q),
        .last_out (last_q),
        .chars    (chars)
    );

    // Per-string parse state and result formation.
    uvtp_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .char_in (char_q),
        .last    (last_q),
        .result  (res_data)
    );

    // Result beat is loaded when the final character is processed.
    uvtp_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && last_q),
        .result_in (res_data),
        .free      (res_free),
        .result    (result)
    );

endmodule

`default_nettype wire

>>> hw/rtl/uvtp_classify.sv
// Character classifier: layout faults, hex detection and nibble value for one character.
`timescale 1ns / 1ps
`default_nettype none

module uvtp_classify
    import uvtp_pkg::*;
(
    input  wire logic [7:0]       char_in,
    input  wire logic [POS_W-1:0] position,
    output uvtp_char_info_t       info
);

    logic hyphen_slot;
    logic is_hyphen;
    logic is_digit;
    logic is_lower;
    logic is_upper;
    logic is_hex;
    logic variant_ok;

    // Character classes.
    assign is_hyphen = (char_in == CHAR_HYPHEN);
    assign is_digit  = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
    assign is_lower  = (char_in >= CHAR_LC_A) && (char_in <= CHAR_LC_F);
    assign is_upper  = (char_in >= CHAR_UC_A) && (char_in <= CHAR_UC_F);
    assign is_hex    = is_digit || is_lower || is_upper;

    // Positions that must hold a hyphen.
    assign hyphen_slot = (position == POS_HYPHEN_A) || (position == POS_HYPHEN_B) ||
                         (position == POS_HYPHEN_C) || (position == POS_HYPHEN_D);

    // Only 8, 9 and lowercase a or b are accepted in the variant position.
    assign variant_ok = (char_in == CHAR_EIGHT) || (char_in == CHAR_NINE) ||
                        (char_in == CHAR_LC_A) || (char_in == CHAR_LC_B);

    // Faults raised by this character; length is judged only at the end.
    always_comb
    begin
        info.fault_set               = '0;
        info.fault_set[FLAG_HYPHEN]  = hyphen_slot && !is_hyphen;
        info.fault_set[FLAG_VERSION] = (position == POS_VERSION) && (char_in != CHAR_FOUR);
        info.fault_set[FLAG_VARIANT] = (position == POS_VARIANT) && !variant_ok;
        info.fault_set[FLAG_NONHEX]  = !is_hyphen && !is_hex;
        info.fault_set[FLAG_STRAY]   = is_hyphen && !hyphen_slot;
    end

    // Nibble value; letters map to ten and up from their low four bits.
    always_comb
    begin
        info.shift_en = is_hex;
        if (is_digit)
        begin
            info.nibble = char_in[3:0];
        end
        else if (is_hex)
        begin
            info.nibble = 4'(char_in[3:0] + 4'd9);
        end
        else
        begin
            info.nibble = 4'd0;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/uvtp_accum.sv
// Parse state: position count, fault flags, 128-bit value and the end-of-string result.
`timescale 1ns / 1ps
`default_nettype none

module uvtp_accum
    import uvtp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] char_in,
    input  wire logic       last,
    output uvtp_result_t    result
);

    logic [POS_W-1:0]  position_reg;
    logic [POS_W-1:0]  position_next;
    logic [FLAG_W-1:0] flags_reg;
    logic [FLAG_W-1:0] flags_next;
    logic [FLAG_W-1:0] flags_final;
    logic [127:0]      value_reg;
    logic [127:0]      value_next;
    logic [127:0]      value_final;
    logic [2:0]        code;
    uvtp_char_info_t   info;

    uvtp_classify u_classify (
        .char_in  (char_in),
        .position (position_reg),
        .info     (info)
    );

    // Flags and value after this character, with the length check on the last beat.
    always_comb
    begin
        flags_final = flags_reg | info.fault_set;
        flags_final[FLAG_LENGTH] = last && (position_reg != POS_LAST);
        if (info.shift_en)
        begin
            value_final = {value_reg[123:0], info.nibble};
        end
        else
        begin
            value_final = value_reg;
        end
    end

    // Lowest set flag gives the reported code.
    always_comb
    begin
        priority if (flags_final[FLAG_LENGTH])
        begin
            code = FAULT_LENGTH;
        end
        else if (flags_final[FLAG_HYPHEN])
        begin
            code = FAULT_HYPHEN;
        end
        else if (flags_final[FLAG_VERSION])
        begin
            code = FAULT_VERSION;
        end
        else if (flags_final[FLAG_VARIANT])
        begin
            code = FAULT_VARIANT;
        end
        else if (flags_final[FLAG_NONHEX])
        begin
            code = FAULT_NONHEX;
        end
        else if (flags_final[FLAG_STRAY])
        begin
            code = FAULT_STRAY;
        end
        else
        begin
            code = FAULT_NONE;
        end
    end

    // Result fields; value halves are zeroed on any fault.
    always_comb
    begin
        result.parse_ok   = (code == FAULT_NONE);
        result.fault_code = code;
        result.value_high = (code == FAULT_NONE) ? value_final[127:64] : 64'd0;
        result.value_low  = (code == FAULT_NONE) ? value_final[63:0] : 64'd0;
    end

    // Next state: clear after the last character, else advance with saturation.
    always_comb
    begin
        position_next = position_reg;
        flags_next    = flags_reg;
        value_next    = value_reg;
        if (step)
        begin
            if (last)
            begin
                position_next = '0;
                flags_next    = '0;
                value_next    = '0;
            end
            else
            begin
                position_next = (position_reg < POS_MAX) ? POS_W'(position_reg + 1'b1) : POS_MAX;
                flags_next    = flags_final;
                value_next    = value_final;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            flags_reg    <= '0;
            value_reg    <= '0;
        end
        else
        begin
            position_reg <= position_next;
            flags_reg    <= flags_next;
            value_reg    <= value_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/uvtp_result_reg.sv
// Result register holding one finished result beat until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module uvtp_result_reg
    import uvtp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  uvtp_result_t   result_in,
    output logic           free,
    uvtp_result_if.source  result
);

    logic         valid_reg;
    logic         valid_next;
    uvtp_result_t data_reg;

    // The slot can take a new result when empty or drained in this cycle.
    assign free = !valid_reg || result.ready;

    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign result.valid      = valid_reg;
    assign result.parse_ok   = data_reg.parse_ok;
    assign result.value_high = data_reg.value_high;
    assign result.value_low  = data_reg.value_low;
    assign result.fault_code = data_reg.fault_code;

endmodule

`default_nettype wire

>>> hw/rtl/uvtp_input_reg.sv
// Input register capturing one character beat ahead of the parse logic.
`timescale 1ns / 1ps
`default_nettype none

module uvtp_input_reg
    import uvtp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  res_free,
    output logic       step,
    output logic [7:0] char_out,
    output logic       last_out,
    uvtp_char_if.sink  chars
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       take;

    // A held character moves on unless it ends a string and the result slot is busy.
    assign step = valid_reg && (!last_reg || res_free);

    assign chars.ready = !valid_reg || step;
    assign take        = chars.valid && chars.ready;
    assign valid_next  = take || (valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= chars.char_in;
            last_reg <= chars.end_mark;
        end
    end

    assign char_out = char_reg;
    assign last_out = last_reg;

endmodule

`default_nettype wire

>>> sim/uuid_parse_checker.sv
// Checker that mirrors the UUID v4 text parser and compares its result beats.
`timescale 1ns / 1ps

module uuid_parse_checker
    import uvtp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    uvtp_char_if   chars,
    uvtp_result_if result,
    output int     fail_count,
    output int     pending
);

    // Parse results still owed by the block, oldest first.
    uvtp_result_t expected_parses[$];

    // Our own copy of the parser state.
    logic [5:0]   text_pos;
    logic [5:0]   seen_faults;
    logic [127:0] digit_bits;

    always @(posedge clk or negedge rst_n)
    begin : watch
        uvtp_result_t want;
        logic [7:0]   ch;
        logic         last;
        logic         slot;
        logic         is_digit;
        logic [3:0]   nib;
        logic [2:0]   code;

        if (!rst_n)
        begin
            expected_parses.delete();
            text_pos    = '0;
            seen_faults = '0;
            digit_bits  = '0;
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            // Result beats are handled first: a beat never belongs to a
            // character accepted at the same edge.
            if (result.valid && result.ready)
            begin
                if (expected_parses.size() == 0)
                begin
                    $error("result beat with no parse pending: ok=%0b high=%h low=%h code=%0d",
                           result.parse_ok, result.value_high, result.value_low,
                           result.fault_code);
                    fail_count++;
                end
                else
                begin
                    want = expected_parses.pop_front();
                    if (result.parse_ok !== want.parse_ok)
                    begin
                        $error("parse_ok: expected %0b, got %0b", want.parse_ok,
                               result.parse_ok);
                        fail_count++;
                    end
                    if (result.value_high !== want.value_high)
                    begin
                        $error("value_high: expected %h, got %h", want.value_high,
                               result.value_high);
                        fail_count++;
                    end
                    if (result.value_low !== want.value_low)
                    begin
                        $error("value_low: expected %h, got %h", want.value_low,
                               result.value_low);
                        fail_count++;
                    end
                    if (result.fault_code !== want.fault_code)
                    begin
                        $error("fault_code: expected %0d, got %0d", want.fault_code,
                               result.fault_code);
                        fail_count++;
                    end
                end
            end

            // Character beats advance the mirrored parse state.
            if (chars.valid && chars.ready)
            begin
                ch   = chars.char_in;
                last = chars.end_mark;
                slot = (text_pos == POS_HYPHEN_A) || (text_pos == POS_HYPHEN_B) ||
                       (text_pos == POS_HYPHEN_C) || (text_pos == POS_HYPHEN_D);

                // Digit value from the low nibble: '0' sits on a nibble
                // boundary, the letters start one above it.
                is_digit = 1'b1;
                nib      = '0;
                if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                    nib = ch[3:0];
                else if (ch >= CHAR_LC_A && ch <= CHAR_LC_F)
                    nib = ch[3:0] + 4'd9;
                else if (ch >= CHAR_UC_A && ch <= CHAR_UC_F)
                    nib = ch[3:0] + 4'd9;
                else
                    is_digit = 1'b0;

                // Layout checks for the fixed positions.
                if (slot && ch != CHAR_HYPHEN)
                    seen_faults[FLAG_HYPHEN] = 1'b1;
                if (text_pos == POS_VERSION && ch != CHAR_FOUR)
                    seen_faults[FLAG_VERSION] = 1'b1;
                if (text_pos == POS_VARIANT && !(ch == CHAR_EIGHT || ch == CHAR_NINE ||
                                                 ch == CHAR_LC_A || ch == CHAR_LC_B))
                    seen_faults[FLAG_VARIANT] = 1'b1;

                // Hyphens outside their slots, non-digits, or a nibble shift.
                if (ch == CHAR_HYPHEN)
                begin
                    if (!slot)
                        seen_faults[FLAG_STRAY] = 1'b1;
                end
                else if (!is_digit)
                    seen_faults[FLAG_NONHEX] = 1'b1;
                else
                    digit_bits = {digit_bits[123:0], nib};

                if (!last)
                begin
                    if (text_pos != POS_MAX)
                        text_pos = text_pos + 6'd1;
                end
                else
                begin
                    if (text_pos != POS_LAST)
                        seen_faults[FLAG_LENGTH] = 1'b1;

                    // The lowest fault code present wins.
                    code = FAULT_NONE;
                    for (int k = FLAG_W - 1; k >= 0; k--)
                        if (seen_faults[k])
                            code = 3'(k + 1);

                    want.parse_ok   = (code == FAULT_NONE);
                    want.value_high = (code == FAULT_NONE) ? digit_bits[127:64] : '0;
                    want.value_low  = (code == FAULT_NONE) ? digit_bits[63:0] : '0;
                    want.fault_code = code;
                    expected_parses.push_back(want);

                    text_pos    = '0;
                    seen_faults = '0;
                    digit_bits  = '0;
                end
            end

            pending = expected_parses.size();
        end
    end

endmodule

>>> sim/testbench.sv
// Top of the UUID v4 text parser testbench: clock, reset, character stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import uvtp_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int LONG_HOLD       = 300;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int DRAIN_CYCLES    = 10;
    localparam logic [7:0] CHAR_LC_G = "g";

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int sender_idle = 0;
    int recv_stall  = 0;
    bit long_hold   = 1'b0;
    int cycle_count = 0;
    int chars_sent  = 0;
    int fail_count;
    int pending;

    // Characters of the string being sent.
    logic [7:0] line_buf[$];

    uvtp_char_if   chars_bus ();
    uvtp_result_if result_bus ();

    uuid_v4_text_parser_core uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_bus),
        .result (result_bus)
    );

    uuid_parse_checker parse_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars_bus),
        .result     (result_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog on the whole run.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Result sink: random stalls, plus one long hold-off when asked.
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic logic [7:0] hex_char(input int unsigned v, input bit upper);
        if (v < 10)
            return CHAR_ZERO + 8'(v);
        return (upper ? CHAR_UC_A : CHAR_LC_A) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] any_hex_char();
        return hex_char($urandom_range(15), 1'($urandom_range(1)));
    endfunction

    // A well-formed version 4 UUID with random digits and mixed case.
    task automatic build_uuid();
        line_buf.delete();
        for (int p = 0; p < 36; p++)
        begin
            if (p == POS_HYPHEN_A || p == POS_HYPHEN_B || p == POS_HYPHEN_C ||
                p == POS_HYPHEN_D)
                line_buf.push_back(CHAR_HYPHEN);
            else if (p == POS_VERSION)
                line_buf.push_back(CHAR_FOUR);
            else if (p == POS_VARIANT)
            begin
                case ($urandom_range(3))
                    0: line_buf.push_back(CHAR_EIGHT);
                    1: line_buf.push_back(CHAR_NINE);
                    2: line_buf.push_back(CHAR_LC_A);
                    default: line_buf.push_back(CHAR_LC_B);
                endcase
            end
            else
                line_buf.push_back(any_hex_char());
        end
    endtask

    // Break one character of the string in one of several ways.
    task automatic corrupt_char();
        int unsigned p;
        p = $urandom_range(line_buf.size() - 1);
        case ($urandom_range(5))
            0: line_buf[p] = 8'($urandom_range(255));
            1: line_buf[p] = CHAR_HYPHEN;
            2: line_buf[POS_VARIANT] = CHAR_UC_A + 8'($urandom_range(1));
            3: line_buf[POS_VERSION] = any_hex_char();
            4: line_buf[p] = CHAR_LC_G + 8'($urandom_range(19));
            default:
            begin
                case ($urandom_range(3))
                    0: line_buf[POS_HYPHEN_A] = any_hex_char();
                    1: line_buf[POS_HYPHEN_B] = any_hex_char();
                    2: line_buf[POS_HYPHEN_C] = any_hex_char();
                    default: line_buf[POS_HYPHEN_D] = any_hex_char();
                endcase
            end
        endcase
    endtask

    // Pick a string: mostly well-formed, some broken, some too short or long, some noise.
    task automatic random_line();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(99);
        if (kind < 85)
            build_uuid();
        if (kind >= 50 && kind < 75)
        begin
            repeat ($urandom_range(1, 2)) corrupt_char();
        end
        else if (kind >= 75 && kind < 85)
        begin
            case ($urandom_range(2))
                0: repeat ($urandom_range(1, 5)) void'(line_buf.pop_back());
                1: repeat ($urandom_range(1, 4)) line_buf.push_back(any_hex_char());
                default:
                begin
                    n = $urandom_range(64, 80);
                    while (line_buf.size() < n)
                        line_buf.push_back(any_hex_char());
                end
            endcase
        end
        else if (kind >= 85)
        begin
            line_buf.delete();
            repeat ($urandom_range(1, 8))
            begin
                case ($urandom_range(3))
                    0: line_buf.push_back(CHAR_HYPHEN);
                    1: line_buf.push_back(any_hex_char());
                    default: line_buf.push_back(8'($urandom_range(255)));
                endcase
            end
        end
    endtask

    // Send the buffered string, marking its final character.
    task automatic send_line();
        bit took;
        for (int i = 0; i < line_buf.size(); i++)
        begin
            while ($urandom_range(99) < sender_idle)
            begin
                chars_bus.valid <= 1'b0;
                @(posedge clk);
            end
            chars_bus.valid    <= 1'b1;
            chars_bus.char_in  <= line_buf[i];
            chars_bus.end_mark <= (i == line_buf.size() - 1);
            do
            begin
                @(negedge clk);
                took = chars_bus.ready;
                @(posedge clk);
            end
            while (!took);
            chars_sent++;
        end
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
        send_line();
    endtask

    // Hold the sender until every owed result has come back.
    task automatic wait_drained();
        chars_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int start;
        sender_idle = idle_pct;
        recv_stall  = stall_pct;
        start       = chars_sent;
        while (chars_sent - start < ITEMS_PER_PHASE)
        begin
            random_line();
            send_line();
        end
        wait_drained();
    endtask

    initial
    begin
        chars_bus.valid    = 1'b0;
        chars_bus.char_in  = '0;
        chars_bus.end_mark = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: value extremes, case mix and each fault kind.
        send_text("00000000-0000-4000-8000-000000000000");
        send_text("ffffffff-ffff-4fff-bfff-ffffffffffff");
        send_text("FFFFFFFF-ABCD-4EF0-9A5B-0123456789Ab");
        send_text("12345678-9abc-4def-a123-456789abcdef");
        send_text("12345678-9abc-4def-A123-456789abcdef");
        send_text("12345678-9abc-4def-B123-456789abcdef");
        send_text("12345678-9abc-5def-8123-456789abcdef");
        send_text("1234567809abc-4def-8123-456789abcdef");
        send_text("12345678-9abc-4deg-8123-456789abcdef");
        send_text("12345678-9abc-4def-8123-4567-9abcdef");
        send_text("12345678-9abc-4deg-8123-4567-9abcdef");
        send_text("12345678-9abc-4def-8123-456789abcde");
        send_text("12345678-9abc-4def-8123-456789abcdef0");
        send_text("x");
        send_text("-");
        send_text("0123456789-0123456789-0123456789-0123456789-0123456789-0123456789");
        build_uuid();
        line_buf[5] = 8'hC3;
        send_line();
        wait_drained();

        // Long result hold-off while single-character strings keep coming.
        long_hold = 1'b1;
        repeat (16)
        begin
            line_buf.delete();
            line_buf.push_back(any_hex_char());
            send_line();
        end
        wait_drained();

        // Random strings under each idling pattern.
        run_phase(0, 0);
        run_phase(60, 0);
        run_phase(0, 60);
        run_phase(33, 33);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
